### sv/msgr_pkg.sv
// shared types and constants of the multi-stop gradient row color block
package msgr_pkg;

  localparam int MAX_STOPS_DEF = 4;
  localparam int FRAC_BITS_DEF = 12;
  localparam int ROW_BITS_DEF  = 12;

  localparam int COLOR_W      = 8;
  localparam int RGB_W        = 3 * COLOR_W;
  localparam int STOP_COUNT_W = 3;
  localparam int LINE_COUNT_W = 13;
  localparam int STATUS_W     = 2;

  // configuration register indexes
  localparam int REG_STOP_COUNT = 0;
  localparam int REG_LINE_COUNT = 1;
  localparam int REG_STOP_WORD0 = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_STOPS   = 2'd1,
    STATUS_DESCENDING = 2'd2,
    STATUS_RANGE      = 2'd3
  } status_t;

endpackage

### sv/msgr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, with sideband data
module msgr_div_pipe #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 13,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic              v   [NUM_W+1];
  logic [NUM_W-1:0]  n   [NUM_W+1];
  logic [DEN_W-1:0]  d   [NUM_W+1];
  logic [DEN_W-1:0]  rem [NUM_W+1];
  logic [NUM_W-1:0]  q   [NUM_W+1];
  logic [SIDE_W-1:0] sd  [NUM_W+1];

  assign v[0]   = in_valid;
  assign n[0]   = num;
  assign d[0]   = den;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign sd[0]  = side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    logic [DEN_W:0] diff;

    // bring down the next numerator bit, msb first
    assign trial = {rem[i], n[i][NUM_W-1-i]};
    assign ge    = trial >= {1'b0, d[i]};
    assign diff  = trial - {1'b0, d[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (advance) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        n[i+1]   <= n[i];
        d[i+1]   <= d[i];
        rem[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q[i+1]   <= {q[i][NUM_W-2:0], ge};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = v[NUM_W];
  assign quot      = q[NUM_W];
  assign side_out  = sd[NUM_W];

endmodule

### sv/msgr_seg_stage.sv
// segment selection stage: picks the stop pair and sets up the interpolation
module msgr_seg_stage #(
  parameter int MAX_STOPS = msgr_pkg::MAX_STOPS_DEF,
  parameter int FRAC_BITS = msgr_pkg::FRAC_BITS_DEF,
  parameter int CNT_W     = 3,
  localparam int SW       = FRAC_BITS + 25,
  localparam int PW       = FRAC_BITS + 1
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      advance,
  input  logic                                      in_valid,
  input  logic [PW-1:0]                             p,
  input  msgr_pkg::status_t                         in_status,
  input  logic [CNT_W-1:0]                          stop_n,
  input  logic [MAX_STOPS-1:0][SW-1:0]              stop_word,
  output logic                                      valid,
  output msgr_pkg::status_t                         status,
  output logic [2:0][msgr_pkg::COLOR_W-1:0]         lo,
  output logic [2:0][msgr_pkg::COLOR_W-1:0]         mag,
  output logic [2:0]                                neg,
  output logic [PW-1:0]                             frac,
  output logic [PW-1:0]                             span
);

  localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [MAX_STOPS-1:0][PW-1:0]               pos;
  logic [MAX_STOPS-1:0][msgr_pkg::RGB_W-1:0]  rgb;
  logic [msgr_pkg::RGB_W-1:0]                 lo_rgb;
  logic [msgr_pkg::RGB_W-1:0]                 hi_rgb;
  logic [PW-1:0]                              s_pos;
  logic [PW-1:0]                              e_pos;
  logic                                       interp;
  logic [2:0][msgr_pkg::COLOR_W-1:0]          lo_next;
  logic [2:0][msgr_pkg::COLOR_W-1:0]          mag_next;
  logic [2:0]                                 neg_next;

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      pos[i] = (stop_word[i][24 +: PW] > ONE) ? ONE : stop_word[i][24 +: PW];
      rgb[i] = stop_word[i][msgr_pkg::RGB_W-1:0];
    end
  end

  always_comb begin
    // past the last stop: color of the last stop in use
    lo_rgb = rgb[0];
    for (int i = 1; i < MAX_STOPS; i++) begin
      if (CNT_W'(i + 1) == stop_n) begin
        lo_rgb = rgb[i];
      end
    end
    hi_rgb = lo_rgb;
    s_pos  = '0;
    e_pos  = '0;
    interp = 1'b0;
    // downward so that the first stop above p wins
    for (int k = MAX_STOPS - 1; k >= 1; k--) begin
      if ((CNT_W'(k) < stop_n) && (p < pos[k])) begin
        lo_rgb = rgb[k-1];
        hi_rgb = rgb[k];
        s_pos  = pos[k-1];
        e_pos  = pos[k];
        interp = 1'b1;
      end
    end
    // below the first stop
    if ((stop_n != '0) && (p < pos[0])) begin
      lo_rgb = rgb[0];
      hi_rgb = rgb[0];
      interp = 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      lo_next[c]  = lo_rgb[16-8*c +: 8];
      neg_next[c] = hi_rgb[16-8*c +: 8] < lo_rgb[16-8*c +: 8];
      mag_next[c] = neg_next[c] ? (lo_rgb[16-8*c +: 8] - hi_rgb[16-8*c +: 8])
                                : (hi_rgb[16-8*c +: 8] - lo_rgb[16-8*c +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= in_status;
      lo     <= lo_next;
      mag    <= mag_next;
      neg    <= neg_next;
      // flat color: zero fraction over a span of one
      frac   <= interp ? (p - s_pos) : '0;
      span   <= interp ? (e_pos - s_pos) : PW'(1);
    end
  end

endmodule

### sv/multi_stop_gradient_row_color_top.sv
// top level of the multi-stop gradient row color block
//
//   channel  | handshake           | payload
//   in       | in_valid / in_stall | row_index
//   out      | out_valid/out_stall | red, green, blue, status
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one row enters per cycle unless in_stall is high; stages in order: checks, row position
// divider, segment selection, multiply, color fraction dividers, output register.
// synchronous reset clears valid bits and loads the register reset values.
// a stalled result holds the whole pipeline; in_stall follows out_stall while a
// result is waiting. cfg_ready is always high.
module multi_stop_gradient_row_color_top #(
  parameter int MAX_STOPS = msgr_pkg::MAX_STOPS_DEF,
  parameter int FRAC_BITS = msgr_pkg::FRAC_BITS_DEF,
  parameter int ROW_BITS  = msgr_pkg::ROW_BITS_DEF,
  localparam int SW       = FRAC_BITS + 25,
  localparam int IW       = $clog2(MAX_STOPS + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ROW_BITS-1:0]           row_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msgr_pkg::COLOR_W-1:0]  red,
  output logic [msgr_pkg::COLOR_W-1:0]  green,
  output logic [msgr_pkg::COLOR_W-1:0]  blue,
  output logic [msgr_pkg::STATUS_W-1:0] status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IW-1:0]                 cfg_index,
  input  logic [SW-1:0]                 cfg_data
);

  localparam int PW     = FRAC_BITS + 1;
  localparam int CNT_W  = ($clog2(MAX_STOPS + 1) > msgr_pkg::STOP_COUNT_W)
                          ? $clog2(MAX_STOPS + 1) : msgr_pkg::STOP_COUNT_W;
  localparam int NUM1_W = ROW_BITS + 1 + FRAC_BITS;
  localparam int NUM2_W = msgr_pkg::COLOR_W + PW;
  localparam int CMP_W  = ROW_BITS + msgr_pkg::LINE_COUNT_W;
  localparam int CW     = msgr_pkg::COLOR_W;
  localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration registers
  logic [msgr_pkg::STOP_COUNT_W-1:0] stop_count;
  logic [msgr_pkg::LINE_COUNT_W-1:0] line_count;
  logic [MAX_STOPS-1:0][SW-1:0]      stop_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= msgr_pkg::STOP_COUNT_W'(1);
      line_count <= msgr_pkg::LINE_COUNT_W'(1);
      stop_word  <= '0;
    end else if (cfg_valid) begin
      priority if (cfg_index == IW'(msgr_pkg::REG_STOP_COUNT)) begin
        stop_count <= cfg_data[msgr_pkg::STOP_COUNT_W-1:0];
      end else if (cfg_index == IW'(msgr_pkg::REG_LINE_COUNT)) begin
        line_count <= cfg_data[msgr_pkg::LINE_COUNT_W-1:0];
      end else begin
        for (int i = 0; i < MAX_STOPS; i++) begin
          if (cfg_index == IW'(msgr_pkg::REG_STOP_WORD0 + i)) begin
            stop_word[i] <= cfg_data;
          end
        end
      end
    end
  end

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stop count saturated to the number of stops built
  logic [CNT_W-1:0] stop_n;
  assign stop_n = (CNT_W'(stop_count) > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS)
                                                           : CNT_W'(stop_count);

  logic              descending;
  logic [PW-1:0]     pos_a;
  logic [PW-1:0]     pos_b;
  msgr_pkg::status_t status0_next;

  always_comb begin
    descending = 1'b0;
    for (int i = 1; i < MAX_STOPS; i++) begin
      pos_a = (stop_word[i][24 +: PW] > ONE) ? ONE : stop_word[i][24 +: PW];
      pos_b = (stop_word[i-1][24 +: PW] > ONE) ? ONE : stop_word[i-1][24 +: PW];
      if ((CNT_W'(i) < stop_n) && (pos_a < pos_b)) begin
        descending = 1'b1;
      end
    end
    pos_a = '0;
    pos_b = '0;
    priority if (stop_n == '0) begin
      status0_next = msgr_pkg::STATUS_NO_STOPS;
    end else if (descending) begin
      status0_next = msgr_pkg::STATUS_DESCENDING;
    end else if (CMP_W'(row_index) >= CMP_W'(line_count)) begin
      status0_next = msgr_pkg::STATUS_RANGE;
    end else begin
      status0_next = msgr_pkg::STATUS_OK;
    end
  end

  // stage 0: checks and position numerator
  logic              s0_valid;
  logic [NUM1_W-1:0] s0_num;
  msgr_pkg::status_t s0_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_num    <= {(ROW_BITS + 1)'(row_index) + (ROW_BITS + 1)'(1), {FRAC_BITS{1'b0}}};
      s0_status <= status0_next;
    end
  end

  // row position divider
  logic                          d1_valid;
  logic [NUM1_W-1:0]             d1_quot;
  logic [msgr_pkg::STATUS_W-1:0] d1_side;

  msgr_div_pipe #(
    .NUM_W (NUM1_W),
    .DEN_W (msgr_pkg::LINE_COUNT_W),
    .SIDE_W(msgr_pkg::STATUS_W)
  ) u_pos_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s0_valid),
    .num      (s0_num),
    .den      (line_count),
    .side     (s0_status),
    .out_valid(d1_valid),
    .quot     (d1_quot),
    .side_out (d1_side)
  );

  // segment selection
  logic                  sg_valid;
  msgr_pkg::status_t     sg_status;
  logic [2:0][CW-1:0]    sg_lo;
  logic [2:0][CW-1:0]    sg_mag;
  logic [2:0]            sg_neg;
  logic [PW-1:0]         sg_frac;
  logic [PW-1:0]         sg_span;

  msgr_seg_stage #(
    .MAX_STOPS(MAX_STOPS),
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W)
  ) u_seg (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (d1_valid),
    .p        (d1_quot[PW-1:0]),
    .in_status(msgr_pkg::status_t'(d1_side)),
    .stop_n   (stop_n),
    .stop_word(stop_word),
    .valid    (sg_valid),
    .status   (sg_status),
    .lo       (sg_lo),
    .mag      (sg_mag),
    .neg      (sg_neg),
    .frac     (sg_frac),
    .span     (sg_span)
  );

  // multiply stage: delta magnitude times fraction
  logic                     m_valid;
  msgr_pkg::status_t        m_status;
  logic [2:0][CW-1:0]       m_lo;
  logic [2:0]               m_neg;
  logic [2:0][NUM2_W-1:0]   m_prod;
  logic [PW-1:0]            m_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= sg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_status <= sg_status;
      m_lo     <= sg_lo;
      m_neg    <= sg_neg;
      m_span   <= sg_span;
      for (int c = 0; c < 3; c++) begin
        m_prod[c] <= NUM2_W'(sg_mag[c]) * NUM2_W'(sg_frac);
      end
    end
  end

  // per channel fraction dividers, quotient magnitude truncates toward zero
  logic                                 dr_valid;
  logic                                 dg_valid;
  logic                                 db_valid;
  logic [NUM2_W-1:0]                    dr_quot;
  logic [NUM2_W-1:0]                    dg_quot;
  logic [NUM2_W-1:0]                    db_quot;
  logic [msgr_pkg::STATUS_W+CW:0]       dr_side;
  logic [CW:0]                          dg_side;
  logic [CW:0]                          db_side;

  msgr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (PW),
    .SIDE_W(msgr_pkg::STATUS_W + CW + 1)
  ) u_red_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (m_valid),
    .num      (m_prod[0]),
    .den      (m_span),
    .side     ({m_status, m_neg[0], m_lo[0]}),
    .out_valid(dr_valid),
    .quot     (dr_quot),
    .side_out (dr_side)
  );

  msgr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (PW),
    .SIDE_W(CW + 1)
  ) u_green_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (m_valid),
    .num      (m_prod[1]),
    .den      (m_span),
    .side     ({m_neg[1], m_lo[1]}),
    .out_valid(dg_valid),
    .quot     (dg_quot),
    .side_out (dg_side)
  );

  msgr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (PW),
    .SIDE_W(CW + 1)
  ) u_blue_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (m_valid),
    .num      (m_prod[2]),
    .den      (m_span),
    .side     ({m_neg[2], m_lo[2]}),
    .out_valid(db_valid),
    .quot     (db_quot),
    .side_out (db_side)
  );

  // output register
  msgr_pkg::status_t fin_status;
  logic [CW-1:0]     red_next;
  logic [CW-1:0]     green_next;
  logic [CW-1:0]     blue_next;

  assign fin_status = msgr_pkg::status_t'(dr_side[msgr_pkg::STATUS_W+CW:CW+1]);

  always_comb begin
    red_next   = dr_side[CW] ? (dr_side[CW-1:0] - dr_quot[CW-1:0])
                             : (dr_side[CW-1:0] + dr_quot[CW-1:0]);
    green_next = dg_side[CW] ? (dg_side[CW-1:0] - dg_quot[CW-1:0])
                             : (dg_side[CW-1:0] + dg_quot[CW-1:0]);
    blue_next  = db_side[CW] ? (db_side[CW-1:0] - db_quot[CW-1:0])
                             : (db_side[CW-1:0] + db_quot[CW-1:0]);
    if (fin_status != msgr_pkg::STATUS_OK) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dr_valid && dg_valid && db_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red    <= red_next;
      green  <= green_next;
      blue   <= blue_next;
      status <= fin_status;
    end
  end

endmodule

### sv/msgr_checker.sv
// port-level checker of the gradient row color block and its bind
module msgr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [msgr_pkg::COLOR_W-1:0]  red,
  input logic [msgr_pkg::COLOR_W-1:0]  green,
  input logic [msgr_pkg::COLOR_W-1:0]  blue,
  input logic [msgr_pkg::STATUS_W-1:0] status
);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // error results carry a black color
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != msgr_pkg::STATUS_W'(msgr_pkg::STATUS_OK))
      |-> (red == '0) && (green == '0) && (blue == '0))
    else $error("error result with nonzero color");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result waiting");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_stop_gradient_row_color_top msgr_checker u_msgr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .red      (red),
  .green    (green),
  .blue     (blue),
  .status   (status)
);

### sim/multi_stop_gradient_row_color_top_tb.sv
// self-checking testbench of the multi-stop gradient row color block
module multi_stop_gradient_row_color_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTOP  = msgr_pkg::MAX_STOPS_DEF;
  localparam int FRAC   = msgr_pkg::FRAC_BITS_DEF;
  localparam int RB     = msgr_pkg::ROW_BITS_DEF;
  localparam int SW     = FRAC + 25;
  localparam int IW     = $clog2(NSTOP + 2);
  localparam int ONE    = 1 << FRAC;
  localparam int DRAIN  = RB + 2 * FRAC + 14 + 10;
  localparam int WD_MAX = 4000;

  typedef struct {
    logic [msgr_pkg::COLOR_W-1:0] red;
    logic [msgr_pkg::COLOR_W-1:0] green;
    logic [msgr_pkg::COLOR_W-1:0] blue;
    msgr_pkg::status_t            status;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RB-1:0] row_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [msgr_pkg::COLOR_W-1:0] red, green, blue;
  logic [msgr_pkg::STATUS_W-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [SW-1:0] cfg_data = '0;

  multi_stop_gradient_row_color_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the registers
  logic [msgr_pkg::STOP_COUNT_W-1:0] shadow_count = 3'd1;
  logic [msgr_pkg::LINE_COUNT_W-1:0] shadow_lines = 13'd1;
  logic [SW-1:0]                     shadow_stop [NSTOP] = '{default: '0};

  logic [RB-1:0] row_reqs [$];
  color_t        color_q [$];
  int            errors = 0;
  bit            quiet = 1'b0;
  bit            hold_start = 1'b0;
  int            hold_left = 0;
  int            in_gap = 0;
  int            out_gap = 0;
  int            idle_cycles = 0;

  function automatic int stop_position(int i);
    int p;
    p = int'(shadow_stop[i][SW-1:msgr_pkg::RGB_W]);
    return (p > ONE) ? ONE : p;
  endfunction

  function automatic int stop_channel(int i, int ch);
    return int'(shadow_stop[i][16-8*ch +: 8]);
  endfunction

  function automatic color_t predict_color(logic [RB-1:0] row);
    color_t c;
    int n, k, p, lo, delta, s, e, v;
    c = '{red: '0, green: '0, blue: '0, status: msgr_pkg::STATUS_OK};
    n = (shadow_count > NSTOP) ? NSTOP : int'(shadow_count);
    if (n == 0) begin
      c.status = msgr_pkg::STATUS_NO_STOPS;
      return c;
    end
    for (int i = 1; i < n; i++)
      if (stop_position(i) < stop_position(i - 1)) begin
        c.status = msgr_pkg::STATUS_DESCENDING;
        return c;
      end
    if (int'(row) >= int'(shadow_lines)) begin
      c.status = msgr_pkg::STATUS_RANGE;
      return c;
    end
    p = ((int'(row) + 1) << FRAC) / int'(shadow_lines);
    k = 0;
    while (k < n && p >= stop_position(k)) k++;
    for (int ch = 0; ch < 3; ch++) begin
      if (k == 0) v = stop_channel(0, ch);
      else if (k == n) v = stop_channel(n - 1, ch);
      else begin
        lo = stop_channel(k - 1, ch);
        delta = stop_channel(k, ch) - lo;
        s = stop_position(k - 1);
        e = stop_position(k);
        v = lo + (delta * (p - s)) / (e - s);
      end
      case (ch)
        0: c.red = v[7:0];
        1: c.green = v[7:0];
        default: c.blue = v[7:0];
      endcase
    end
    return c;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        color_q.push_back(predict_color(row_index));
        void'(row_reqs.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (row_reqs.size() > 0) begin
          in_valid <= 1'b1;
          row_index <= row_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    color_t x;
    bit burst;
    if (!rst && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        errors++;
      end else begin
        x = color_q.pop_front();
        if (red !== x.red) begin
          $error("red: expected %0d, actual %0d", x.red, red);
          errors++;
        end
        if (green !== x.green) begin
          $error("green: expected %0d, actual %0d", x.green, green);
          errors++;
        end
        if (blue !== x.blue) begin
          $error("blue: expected %0d, actual %0d", x.blue, blue);
          errors++;
        end
        if (status !== x.status) begin
          $error("status: expected %0d, actual %0d", x.status, status);
          errors++;
        end
      end
    end
    burst = 1'b0;
    if (out_gap > 0) begin
      out_gap--;
      burst = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 10) - 1;
      burst = 1'b1;
    end
    out_stall <= burst || (hold_left > 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WD_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic reg_write(int idx, logic [SW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= IW'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == msgr_pkg::REG_STOP_COUNT)
      shadow_count = data[msgr_pkg::STOP_COUNT_W-1:0];
    else if (idx == msgr_pkg::REG_LINE_COUNT)
      shadow_lines = data[msgr_pkg::LINE_COUNT_W-1:0];
    else if (idx < msgr_pkg::REG_STOP_WORD0 + NSTOP)
      shadow_stop[idx - msgr_pkg::REG_STOP_WORD0] = data;
  endtask

  task automatic drain();
    wait (row_reqs.size() == 0 && !in_valid && color_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] stop_word(int pos, logic [23:0] rgb);
    return {13'(pos), rgb};
  endfunction

  task automatic set_stops(int cnt, int lines, int p0, int p1, int p2, int p3);
    reg_write(msgr_pkg::REG_STOP_COUNT, SW'(cnt));
    reg_write(msgr_pkg::REG_LINE_COUNT, SW'(lines));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 0, stop_word(p0, 24'($urandom)));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 1, stop_word(p1, 24'($urandom)));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 2, stop_word(p2, 24'($urandom)));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 3, stop_word(p3, 24'($urandom)));
  endtask

  task automatic random_rows(int num);
    int lim;
    for (int i = 0; i < num; i++) begin
      lim = (shadow_lines == 0 || shadow_lines > 4096) ? 4096 : int'(shadow_lines);
      if ($urandom_range(0, 4) == 0) row_reqs.push_back(RB'($urandom));
      else row_reqs.push_back(RB'($urandom_range(0, lim - 1)));
    end
  endtask

  initial begin
    int pos [4];
    int lines;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: single stop, one line
    row_reqs.push_back(RB'(0));
    row_reqs.push_back(RB'(1));
    row_reqs.push_back(RB'(4095));
    drain();

    // full height, four stops over the whole range
    reg_write(msgr_pkg::REG_STOP_COUNT, SW'(4));
    reg_write(msgr_pkg::REG_LINE_COUNT, SW'(4096));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 0, stop_word(0, 24'hFF0000));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 1, stop_word(1365, 24'h00FF00));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 2, stop_word(2730, 24'h0000FF));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 3, stop_word(4096, 24'hFFFFFF));
    // indexes past the list are ignored
    reg_write(6, '1);
    reg_write(7, '1);
    foreach (pos[i]) pos[i] = 0;
    row_reqs.push_back(RB'(0));
    row_reqs.push_back(RB'(1));
    row_reqs.push_back(RB'(1364));
    row_reqs.push_back(RB'(2047));
    row_reqs.push_back(RB'(4094));
    row_reqs.push_back(RB'(4095));
    drain();

    // no stops
    reg_write(msgr_pkg::REG_STOP_COUNT, SW'(0));
    row_reqs.push_back(RB'(5));
    row_reqs.push_back(RB'(4095));
    drain();

    // descending stops, checked ahead of the row range
    set_stops(3, 100, 1000, 500, 3000, 0);
    row_reqs.push_back(RB'(10));
    row_reqs.push_back(RB'(200));
    drain();

    // count saturates, positions above one, equal positions, all-ones words
    reg_write(msgr_pkg::REG_STOP_COUNT, SW'(7));
    reg_write(msgr_pkg::REG_LINE_COUNT, SW'(8191));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 0, stop_word(512, 24'h123456));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 1, stop_word(512, 24'hABCDEF));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 2, stop_word(8191, 24'h00FF80));
    reg_write(msgr_pkg::REG_STOP_WORD0 + 3, '1);
    row_reqs.push_back(RB'(0));
    row_reqs.push_back(RB'(1024));
    row_reqs.push_back(RB'(4095));
    drain();

    // zero height
    reg_write(msgr_pkg::REG_LINE_COUNT, SW'(0));
    row_reqs.push_back(RB'(0));
    row_reqs.push_back(RB'(77));
    drain();

    // random settings; one phase holds the receiver off, the last one runs without gaps
    for (int ph = 0; ph < 10; ph++) begin
      pos[0] = $urandom_range(0, 1500);
      for (int i = 1; i < 4; i++)
        pos[i] = ($urandom_range(0, 5) == 0) ? pos[i-1] : pos[i-1] + $urandom_range(1, 1600);
      if ($urandom_range(0, 5) == 0) pos[$urandom_range(0, 3)] = $urandom_range(0, 8191);
      case ($urandom_range(0, 4))
        0: lines = 4096;
        1: lines = 1;
        2: lines = $urandom_range(1, 16);
        default: lines = $urandom_range(1, 4096);
      endcase
      set_stops($urandom_range(0, 7), lines, pos[0], pos[1], pos[2], pos[3]);
      if (ph == 9) quiet = 1'b1;
      random_rows(ph == 4 ? 150 : 55);
      if (ph == 4) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
sv/msgr_pkg.sv
sv/msgr_div_pipe.sv
sv/msgr_seg_stage.sv
sv/multi_stop_gradient_row_color_top.sv
sv/msgr_checker.sv
sim/multi_stop_gradient_row_color_top_tb.sv
